// File: src/mvc_pkg.sv
// ----------------------------------------------------------------------------
// mvc_pkg: shared types and constants of the vertex canonicalizer
// element kinds, vertex widths and the stage-to-stage control struct
// ----------------------------------------------------------------------------
package mvc_pkg;

    localparam int VERT_W    = 31;
    localparam int NUM_VERT  = 8;
    localparam int FACE_VERT = 4;
    localparam int POS_W     = $clog2(NUM_VERT);

    // element kind code; the fourth code names no element
    typedef enum logic [1:0] {
        KIND_TRI  = 2'd0,
        KIND_QUAD = 2'd1,
        KIND_HEX  = 2'd2
    } kind_t;

    typedef logic [VERT_W-1:0]                vert_t;
    typedef logic [NUM_VERT-1:0][VERT_W-1:0]  vert_vec_t;

    // minimum search result handed to the reorder stage
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [POS_W-1:0]  pos;
    } min_info_t;

endpackage

// File: src/mvc_min_find.sv
// ----------------------------------------------------------------------------
// mvc_min_find: first-minimum search
// finds the lowest position holding the smallest index, registered output
// ----------------------------------------------------------------------------
module mvc_min_find
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  mvc_pkg::kind_t      in_kind,
    input  mvc_pkg::vert_vec_t  in_vert,
    output mvc_pkg::min_info_t  info,
    output mvc_pkg::vert_vec_t  vert
);

    mvc_pkg::min_info_t info_reg;
    mvc_pkg::min_info_t info_next;
    mvc_pkg::vert_vec_t vert_reg;

    logic [mvc_pkg::POS_W-1:0] pos01, pos23, pos45, pos67, pos_q, pos_h, pos_t, pos_x;
    mvc_pkg::vert_t            val01, val23, val45, val67, val_q, val_h;

    // pairwise tree; the right side wins only when strictly smaller
    always_comb
    begin
        pos01 = (in_vert[1] < in_vert[0]) ? mvc_pkg::POS_W'(1) : mvc_pkg::POS_W'(0);
        val01 = (in_vert[1] < in_vert[0]) ? in_vert[1] : in_vert[0];
        pos23 = (in_vert[3] < in_vert[2]) ? mvc_pkg::POS_W'(3) : mvc_pkg::POS_W'(2);
        val23 = (in_vert[3] < in_vert[2]) ? in_vert[3] : in_vert[2];
        pos45 = (in_vert[5] < in_vert[4]) ? mvc_pkg::POS_W'(5) : mvc_pkg::POS_W'(4);
        val45 = (in_vert[5] < in_vert[4]) ? in_vert[5] : in_vert[4];
        pos67 = (in_vert[7] < in_vert[6]) ? mvc_pkg::POS_W'(7) : mvc_pkg::POS_W'(6);
        val67 = (in_vert[7] < in_vert[6]) ? in_vert[7] : in_vert[6];

        pos_t = (in_vert[2] < val01) ? mvc_pkg::POS_W'(2) : pos01;
        pos_q = (val23 < val01) ? pos23 : pos01;
        val_q = (val23 < val01) ? val23 : val01;
        pos_h = (val67 < val45) ? pos67 : pos45;
        val_h = (val67 < val45) ? val67 : val45;
        pos_x = (val_h < val_q) ? pos_h : pos_q;

        info_next.valid = in_valid;
        info_next.kind  = in_kind;
        case (in_kind)
            mvc_pkg::KIND_TRI:  info_next.pos = pos_t;
            mvc_pkg::KIND_QUAD: info_next.pos = pos_q;
            mvc_pkg::KIND_HEX:  info_next.pos = pos_x;
            default:            info_next.pos = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg <= '0;
        end
        else
        begin
            info_reg <= info_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vert_reg <= in_vert;
    end

    assign info = info_reg;
    assign vert = vert_reg;

endmodule

// File: src/mvc_reorder.sv
// ----------------------------------------------------------------------------
// mvc_reorder: vertex rotation and face swap
// rotates faces so the minimum leads, zeroes unused slots, registered output
// ----------------------------------------------------------------------------
module mvc_reorder
(
    input  logic                clk,
    input  logic                rst_n,
    input  mvc_pkg::min_info_t  info,
    input  mvc_pkg::vert_vec_t  vert,
    output logic                res_valid,
    output mvc_pkg::vert_vec_t  res_vert
);

    logic               valid_reg;
    mvc_pkg::vert_vec_t vert_reg;
    mvc_pkg::vert_vec_t vert_next;

    always_comb
    begin
        logic [1:0] k;
        logic [1:0] fwd;
        logic [1:0] rev;
        logic [2:0] tri_idx;

        k         = info.pos[1:0];
        fwd       = '0;
        rev       = '0;
        tri_idx   = '0;
        vert_next = '0;
        case (info.kind)
            mvc_pkg::KIND_TRI:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tri_idx = 3'(info.pos) + 3'(i);
                    if (tri_idx >= 3'd3)
                    begin
                        tri_idx = tri_idx - 3'd3;
                    end
                    vert_next[i] = vert[tri_idx];
                end
            end
            mvc_pkg::KIND_QUAD:
            begin
                for (int i = 0; i < mvc_pkg::FACE_VERT; i++)
                begin
                    fwd          = k + 2'(i);
                    vert_next[i] = vert[{1'b0, fwd}];
                end
            end
            mvc_pkg::KIND_HEX:
            begin
                for (int i = 0; i < mvc_pkg::FACE_VERT; i++)
                begin
                    fwd = k + 2'(i);
                    rev = k - 2'(i);
                    if (!info.pos[2])
                    begin
                        vert_next[i]                      = vert[{1'b0, fwd}];
                        vert_next[mvc_pkg::FACE_VERT + i] = vert[{1'b1, fwd}];
                    end
                    else
                    begin
                        // top face reversed becomes the bottom
                        vert_next[i]                      = vert[{1'b1, rev}];
                        vert_next[mvc_pkg::FACE_VERT + i] = vert[{1'b0, rev}];
                    end
                end
            end
            default:
            begin
                vert_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= info.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vert_reg <= vert_next;
    end

    assign res_valid = valid_reg;
    assign res_vert  = vert_reg;

endmodule

// File: src/mesh_element_vertex_canonicalizer.sv
// ----------------------------------------------------------------------------
// mesh_element_vertex_canonicalizer: canonical vertex order of mesh elements
// done: result strobe, the start beat carried through the pipeline registers listed below
// throughput: one element per cycle; busy is always low
// pipeline: input register, minimum search register, reorder result register
// reset: rst_n asynchronous active low clears the valid bits; no results pending
// results cannot be stalled by the receiver: done marks a one-cycle beat
// ----------------------------------------------------------------------------
module mesh_element_vertex_canonicalizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [30:0] vertex_0,
    input  logic [30:0] vertex_1,
    input  logic [30:0] vertex_2,
    input  logic [30:0] vertex_3,
    input  logic [30:0] vertex_4,
    input  logic [30:0] vertex_5,
    input  logic [30:0] vertex_6,
    input  logic [30:0] vertex_7,
    output logic        done,
    output logic [30:0] out_vertex_0,
    output logic [30:0] out_vertex_1,
    output logic [30:0] out_vertex_2,
    output logic [30:0] out_vertex_3,
    output logic [30:0] out_vertex_4,
    output logic [30:0] out_vertex_5,
    output logic [30:0] out_vertex_6,
    output logic [30:0] out_vertex_7
);

    // input stage registers; only the valid bit is reset
    logic               in_valid_reg;
    mvc_pkg::kind_t     kind_reg;
    mvc_pkg::vert_vec_t vert_reg;

    // between search and reorder stages
    mvc_pkg::min_info_t min_info;
    mvc_pkg::vert_vec_t min_vert;

    // reorder stage outputs
    logic               res_valid;
    mvc_pkg::vert_vec_t res_vert;

    // every stage moves each cycle, so no beat is ever refused
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    // capture the element; payload needs no reset
    always_ff @(posedge clk)
    begin
        kind_reg <= mvc_pkg::kind_t'(command);
        vert_reg <= {vertex_7, vertex_6, vertex_5, vertex_4,
                     vertex_3, vertex_2, vertex_1, vertex_0};
    end

    // first occurrence of the smallest index among the element's vertices
    mvc_min_find u_min_find
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_kind  (kind_reg),
        .in_vert  (vert_reg),
        .info     (min_info),
        .vert     (min_vert)
    );

    // rotate (or flip for a top-face minimum) and zero the unused slots
    mvc_reorder u_reorder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .info      (min_info),
        .vert      (min_vert),
        .res_valid (res_valid),
        .res_vert  (res_vert)
    );

    assign done         = res_valid;
    assign out_vertex_0 = res_vert[0];
    assign out_vertex_1 = res_vert[1];
    assign out_vertex_2 = res_vert[2];
    assign out_vertex_3 = res_vert[3];
    assign out_vertex_4 = res_vert[4];
    assign out_vertex_5 = res_vert[5];
    assign out_vertex_6 = res_vert[6];
    assign out_vertex_7 = res_vert[7];

endmodule
